>>> design/charlieplex_matrix_scanner_core_macros.svh
// Assertion helpers for the matrix scanner core.
`ifndef CHARLIEPLEX_MATRIX_SCANNER_CORE_MACROS_SVH
`define CHARLIEPLEX_MATRIX_SCANNER_CORE_MACROS_SVH

// Clocked check with an explicit clock and active-low reset
`define CPMS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check on the core clock and reset
`define CPMS_ASSERT(lbl, prop, msg) \
    `CPMS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> design/cpms_pkg.sv
package cpms_pkg;

    localparam int MATRIX_ROWS  = 9;
    localparam int MATRIX_COLS  = 14;
    localparam int CONTROL_PINS = 12;

    localparam int ROW_IDX_W = 4;
    localparam int PHASE_W   = 4;
    localparam int COLUMN_W  = 8;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_LOAD_ROW  = 2'd0;
    localparam logic [1:0] ACT_SHIFT_COL = 2'd1;
    localparam logic [1:0] ACT_CLEAR     = 2'd2;
    localparam logic [1:0] ACT_SCAN_TICK = 2'd3;

    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(CONTROL_PINS - 1);

    typedef logic [MATRIX_COLS-1:0]  t_row;
    typedef logic [CONTROL_PINS-1:0] t_pins;
    typedef logic [PHASE_W-1:0]      t_phase;

    // Anode pin of pixel (r, c): columns 0..7 and the even right-hand columns use pin r,
    // the odd right-hand columns use pins 9, 10, 11
    function automatic t_phase pix_anode(input int r, input int c);
        t_phase a;
        a = PHASE_W'(r);
        if (c >= 8 && (c % 2) == 1) begin
            a = PHASE_W'(9 + (c - 8) / 2);
        end
        return a;
    endfunction

    // Cathode pin of pixel (r, c): columns 0..7 count down from pin 8 skipping pin r
    function automatic t_phase pix_cathode(input int r, input int c);
        t_phase k;
        if (c < 8) begin
            k = (8 - c > r) ? PHASE_W'(8 - c) : PHASE_W'(7 - c);
        end else if ((c % 2) == 0) begin
            k = PHASE_W'(9 + (c - 8) / 2);
        end else begin
            k = PHASE_W'(r);
        end
        return k;
    endfunction

endpackage

>>> design/charlieplex_matrix_scanner_core.sv
// Charlieplexed LED matrix scanner, 9 rows by 14 columns on 12 control pins.
// Input stream (s_axis): tuser carries the action (load row, shift in column,
// clear picture, scan tick); tdata carries the row index, row bits and column
// byte. Only a scan tick gives an output word on the m_axis stream: the phase,
// the pin drive enables and the pin high levels for that slot.
// Each input word is registered, then processed in one pass: the picture is
// updated or the pin pattern for the current phase is formed into the output
// register. A tick's output word passes through the input register and then the
// output register; one word is taken every cycle while the output side keeps up.
// The throughput is set by the single output register: when the receiver
// stalls, a scan tick waits in the input register and s_axis tready drops;
// load, shift and clear words keep flowing only until a tick is held.
// Synchronous active-low reset clears the picture, sets phase 0 and empties
// both registers.
`include "charlieplex_matrix_scanner_core_macros.svh"

module charlieplex_matrix_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // row_index[3:0], row_bits[17:4], column_bits[25:18]
    input  logic [1:0]  i_s_axis_tuser,   // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // scan_phase[3:0], pin_drive_enable[15:4],
                                          // pin_level_high[27:16]
);

    // Input register
    logic                                r_in_valid;
    logic [1:0]                          r_action;
    logic [cpms_pkg::ROW_IDX_W-1:0]      r_row_index;
    cpms_pkg::t_row                      r_row_bits;
    logic [cpms_pkg::COLUMN_W-1:0]       r_column;

    // Picture and phase state
    cpms_pkg::t_row                      r_pic [cpms_pkg::MATRIX_ROWS];
    cpms_pkg::t_phase                    r_phase;

    // Result register
    logic                                r_out_valid;
    cpms_pkg::t_phase                    r_out_phase;
    cpms_pkg::t_pins                     r_out_enable;
    cpms_pkg::t_pins                     r_out_high;

    logic             is_tick;
    logic             out_free;
    logic             consume;
    cpms_pkg::t_pins  n_low;
    cpms_pkg::t_pins  n_high;
    cpms_pkg::t_phase n_phase;

    assign is_tick  = (r_action == cpms_pkg::ACT_SCAN_TICK);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign consume  = r_in_valid && (!is_tick || out_free);

    assign o_s_axis_tready = !r_in_valid || consume;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_high, r_out_enable, r_out_phase};

    // Gather the cathodes of every lit pixel whose anode is the current phase
    always_comb begin
        n_low = '0;
        for (int r = 0; r < cpms_pkg::MATRIX_ROWS; r++) begin
            for (int c = 0; c < cpms_pkg::MATRIX_COLS; c++) begin
                if (r_pic[r][c] && (cpms_pkg::pix_anode(r, c) == r_phase)) begin
                    n_low[cpms_pkg::pix_cathode(r, c)] = 1'b1;
                end
            end
        end
        n_high = cpms_pkg::t_pins'(1) << r_phase;
        n_low  = n_low & ~n_high;
    end

    assign n_phase = (r_phase == cpms_pkg::LAST_PHASE) ? '0 : r_phase + 1'b1;

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_action    <= i_s_axis_tuser;
            r_row_index <= i_s_axis_tdata[3:0];
            r_row_bits  <= i_s_axis_tdata[17:4];
            r_column    <= i_s_axis_tdata[25:18];
        end
    end

    // Apply the action to the picture and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < cpms_pkg::MATRIX_ROWS; r++) begin
                r_pic[r] <= '0;
            end
            r_phase <= '0;
        end else if (consume) begin
            case (r_action)
                cpms_pkg::ACT_LOAD_ROW: begin
                    if (r_row_index < cpms_pkg::ROW_IDX_W'(cpms_pkg::MATRIX_ROWS)) begin
                        r_pic[r_row_index] <= r_row_bits;
                    end
                end
                cpms_pkg::ACT_SHIFT_COL: begin
                    // Scroll left; rows 1..7 take column bit 7-y at the right edge
                    r_pic[0] <= r_pic[0] >> 1;
                    for (int y = 1; y < 8; y++) begin
                        r_pic[y] <= {r_column[7 - y], r_pic[y][cpms_pkg::MATRIX_COLS-1:1]};
                    end
                    r_pic[8] <= r_pic[8] >> 1;
                end
                cpms_pkg::ACT_CLEAR: begin
                    for (int r = 0; r < cpms_pkg::MATRIX_ROWS; r++) begin
                        r_pic[r] <= '0;
                    end
                end
                cpms_pkg::ACT_SCAN_TICK: begin
                    r_phase <= n_phase;
                end
                default: begin
                    r_phase <= r_phase;
                end
            endcase
        end
    end

    // Load the result register on a tick, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (consume && is_tick) begin
            r_out_phase  <= r_phase;
            r_out_enable <= n_high | n_low;
            r_out_high   <= n_high;
        end
    end

    `CPMS_ASSERT(a_phase_range, r_phase <= cpms_pkg::LAST_PHASE, "phase counter beyond last pin")
    `CPMS_ASSERT(a_high_onehot, r_out_valid |-> $onehot(r_out_high), "high level not one-hot")
    `CPMS_ASSERT(a_high_matches_phase,
        r_out_valid |-> (r_out_high == (cpms_pkg::t_pins'(1) << r_out_phase)),
        "high pin differs from phase")
    `CPMS_ASSERT(a_high_is_driven,
        r_out_valid |-> ((r_out_high & ~r_out_enable) == '0),
        "high pin not driven")

endmodule
